// ----- rtl/core/dedl_pkg.sv -----
package dedl_pkg;

  localparam int CAPACITY = 256;
  localparam int ELEM_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 3;
  localparam int POS_W    = 9;
  localparam int FILL_W   = 9;
  localparam int STAT_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REM_TAIL = 3'd3,
    CMD_RD_HEAD  = 3'd4,
    CMD_RD_TAIL  = 3'd5,
    CMD_RD_INDEX = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // One access to the slot memory per transaction.
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [ELEM_W-1:0] wdata;
  } mem_req_t;

  // Result fields known at acceptance; the element itself follows from memory.
  typedef struct packed {
    status_t           status;
    logic [FILL_W-1:0] fill;
    logic              use_mem;
  } res_t;

  // Physical slot of a logical position; the sum stays below twice the capacity.
  function automatic logic [ADDR_W-1:0] ring_slot(input logic [ADDR_W-1:0] head,
                                                  input logic [ADDR_W-1:0] logical);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, logical};
    if (sum >= (ADDR_W+1)'(CAPACITY)) begin
      sum = sum - (ADDR_W+1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/core/bounded_double_ended_list_core.sv -----
// Fixed-capacity double-ended list of 256 words of 32 bits, kept as a ring in a
// single-port slot memory with a head pointer and an element count. Every command
// (insert, remove or read at either end, read by logical index from the head)
// produces exactly one result transaction carrying the element read, the fill count
// after the command and a status. The block accepts one command per clock cycle and
// returns its result in the cycle after acceptance; that timing is set by the slot
// memory, which each command uses at most once, either for a write or for a
// registered read. Commands that write update the memory at the acceptance edge, so
// a read in the very next cycle already sees the new contents. No clearing pass
// runs after reset: a slot beyond the fill count is never read from memory and
// returns zero, which matches a store that is zero wherever it is unoccupied. While
// a result is held by out_stall, in_stall is raised and the next command waits.
module bounded_double_ended_list_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dedl_pkg::CMD_W-1:0]    cmd,
  input  logic [dedl_pkg::ELEM_W-1:0]   element,
  input  logic [dedl_pkg::POS_W-1:0]    position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dedl_pkg::ELEM_W-1:0]   read_element,
  output logic [dedl_pkg::FILL_W-1:0]   fill_count,
  output logic [dedl_pkg::STAT_W-1:0]   status
);
  import dedl_pkg::*;

  logic              accept;
  mem_req_t          mem_req;
  res_t              res;
  logic [ELEM_W-1:0] mem_rdata;

  // Result stage: everything known at acceptance, waiting for the memory read data.
  logic              res_valid;
  res_t              res_q;

  // A new command may enter whenever the held result leaves in the same cycle.
  assign in_stall = res_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  dedl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd),
    .element  (element),
    .position (position),
    .mem_req  (mem_req),
    .res      (res)
  );

  // The read data register only loads on an accepted read, so it holds while stalled.
  dedl_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!in_stall) begin
      res_valid <= in_valid;
    end
    if (accept) begin
      res_q <= res;
    end
  end

  // Non-read commands and errors report a zero element.
  assign out_valid    = res_valid;
  assign read_element = res_q.use_mem ? mem_rdata : '0;
  assign fill_count   = res_q.fill;
  assign status       = res_q.status;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(fill_count) <= 32'(CAPACITY)))
    else $error("fill count exceeds capacity");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (32'(fill_count) == 32'(CAPACITY)))
    else $error("full status with list not full");

  a_empty_means_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (fill_count == '0))
    else $error("empty status with elements held");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (read_element == '0))
    else $error("element returned with error status");
`endif

endmodule

// ----- rtl/core/dedl_ram.sv -----
module dedl_ram (
  input  logic                      clk,
  input  dedl_pkg::mem_req_t        req,
  output logic [dedl_pkg::ELEM_W-1:0] rdata
);
  import dedl_pkg::*;

  logic [ELEM_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

// ----- rtl/core/dedl_ctrl.sv -----
module dedl_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [dedl_pkg::CMD_W-1:0]   cmd,
  input  logic [dedl_pkg::ELEM_W-1:0]  element,
  input  logic [dedl_pkg::POS_W-1:0]   position,
  output dedl_pkg::mem_req_t           mem_req,
  output dedl_pkg::res_t               res
);
  import dedl_pkg::*;

  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] head_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic              is_full;
  logic              is_empty;
  logic [ADDR_W-1:0] tail_logical;
  logic [ADDR_W-1:0] last_logical;
  logic [ADDR_W-1:0] head_dec;
  logic [ADDR_W-1:0] head_inc;
  logic              pos_in_range;
  logic              pos_occupied;
  logic              mem_en;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [ELEM_W-1:0] mem_wdata;
  status_t           status;
  logic              use_mem;

  always_comb begin
    is_full      = (count >= CNT_W'(CAPACITY));
    is_empty     = (count == '0);
    tail_logical = ADDR_W'(count);
    last_logical = ADDR_W'(count - CNT_W'(1));
    head_dec     = (head == '0) ? ADDR_W'(CAPACITY - 1) : head - ADDR_W'(1);
    head_inc     = (head == ADDR_W'(CAPACITY - 1)) ? '0 : head + ADDR_W'(1);
    pos_in_range = (32'(position) < 32'(CAPACITY));
    pos_occupied = (32'(position) < 32'(count));
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = head;
    mem_wdata  = '0;
    status     = ST_OK;
    use_mem    = 1'b0;
    unique case (cmd_t'(cmd))
      CMD_INS_HEAD: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          head_next  = head_dec;
          count_next = count + CNT_W'(1);
          mem_en     = 1'b1;
          mem_we     = 1'b1;
          mem_addr   = head_dec;
          mem_wdata  = element;
        end
      end
      CMD_INS_TAIL: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
          mem_en     = 1'b1;
          mem_we     = 1'b1;
          mem_addr   = ring_slot(head, tail_logical);
          mem_wdata  = element;
        end
      end
      CMD_REM_HEAD: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count - CNT_W'(1);
          mem_en     = 1'b1;
          mem_we     = 1'b1;
          mem_addr   = head;
        end
      end
      CMD_REM_TAIL: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
          mem_en     = 1'b1;
          mem_we     = 1'b1;
          mem_addr   = ring_slot(head, last_logical);
        end
      end
      CMD_RD_HEAD: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          mem_en   = 1'b1;
          mem_addr = head;
          use_mem  = 1'b1;
        end
      end
      CMD_RD_TAIL: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          mem_en   = 1'b1;
          mem_addr = ring_slot(head, last_logical);
          use_mem  = 1'b1;
        end
      end
      CMD_RD_INDEX: begin
        if (!pos_in_range) begin
          status = ST_RANGE;
        end else begin
          // Slots beyond the fill count are not read and return zero, so only occupied ones are read.
          mem_en   = pos_occupied;
          mem_addr = ring_slot(head, ADDR_W'(position));
          use_mem  = pos_occupied;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_req.en    = accept && mem_en;
    mem_req.we    = mem_we;
    mem_req.addr  = mem_addr;
    mem_req.wdata = mem_wdata;
    res.status    = status;
    res.fill      = FILL_W'(count_next);
    res.use_mem   = use_mem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (accept) begin
      head  <= head_next;
      count <= count_next;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import dedl_pkg::*;

  // The command field is three bits wide, so the one code that the block does not
  // define can still arrive; it must leave the list alone and report success.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 750;
  localparam int HOLD_CYCLES  = 50;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  // Tracks the list contents as the block should hold them and keeps the results
  // that accepted commands still owe, oldest first.
  class deque_scoreboard;
    typedef struct {
      logic [ELEM_W-1:0] word;
      logic [FILL_W-1:0] fill;
      status_t           status;
    } deque_result_t;

    logic [ELEM_W-1:0] ring [CAPACITY];
    logic [ADDR_W-1:0] front;
    int unsigned       occupancy;
    deque_result_t     awaited_results[$];
    int unsigned       results_seen;
    int unsigned       failures;

    function new();
      foreach (ring[i]) ring[i] = '0;
      front        = '0;
      occupancy    = 0;
      results_seen = 0;
      failures     = 0;
    endfunction

    function void note_command(logic [CMD_W-1:0] code, logic [ELEM_W-1:0] word,
                               logic [POS_W-1:0] pos);
      deque_result_t     res;
      logic [ADDR_W-1:0] slot;
      res.word   = '0;
      res.status = ST_OK;
      case (code)
        CMD_INS_HEAD: begin
          if (occupancy == CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            front       = front - 1'b1;
            ring[front] = word;
            occupancy++;
          end
        end
        CMD_INS_TAIL: begin
          if (occupancy == CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            slot       = front + ADDR_W'(occupancy);
            ring[slot] = word;
            occupancy++;
          end
        end
        CMD_REM_HEAD: begin
          if (occupancy == 0) begin
            res.status = ST_EMPTY;
          end else begin
            ring[front] = '0;
            front       = front + 1'b1;
            occupancy--;
          end
        end
        CMD_REM_TAIL: begin
          if (occupancy == 0) begin
            res.status = ST_EMPTY;
          end else begin
            slot       = front + ADDR_W'(occupancy - 1);
            ring[slot] = '0;
            occupancy--;
          end
        end
        CMD_RD_HEAD: begin
          if (occupancy == 0) res.status = ST_EMPTY;
          else res.word = ring[front];
        end
        CMD_RD_TAIL: begin
          if (occupancy == 0) begin
            res.status = ST_EMPTY;
          end else begin
            slot     = front + ADDR_W'(occupancy - 1);
            res.word = ring[slot];
          end
        end
        CMD_RD_INDEX: begin
          if (pos >= CAPACITY) begin
            res.status = ST_RANGE;
          end else begin
            slot     = front + pos[ADDR_W-1:0];
            res.word = ring[slot];
          end
        end
        default: begin
        end
      endcase
      res.fill = FILL_W'(occupancy);
      awaited_results.push_back(res);
    endfunction

    function void check_result(logic [ELEM_W-1:0] word, logic [FILL_W-1:0] fill,
                               logic [STAT_W-1:0] st);
      deque_result_t res;
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none outstanding: element %h fill %0d status %0d",
                 $time, word, fill, st);
        failures++;
        return;
      end
      res = awaited_results.pop_front();
      if (word !== res.word) begin
        $display("%0t: read_element expected %h, actual %h", $time, res.word, word);
        failures++;
      end
      if (fill !== res.fill) begin
        $display("%0t: fill_count expected %0d, actual %0d", $time, res.fill, fill);
        failures++;
      end
      if (st !== res.status) begin
        $display("%0t: status expected %s, actual %0d", $time, res.status.name(), st);
        failures++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  cmd = CMD_RD_HEAD;
  logic [ELEM_W-1:0] element = '0;
  logic [POS_W-1:0]  position = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ELEM_W-1:0] read_element;
  logic [FILL_W-1:0] fill_count;
  logic [STAT_W-1:0] status;

  deque_scoreboard sb = new();

  // Idle rates in percent of cycles; the stimulus process moves them through the
  // three traffic profiles.
  int unsigned sender_idle_pct   = 26;
  int unsigned receiver_idle_pct = 53;
  int unsigned cycle_count       = 0;

  bounded_double_ended_list_core u_top (.*);

  always #10 clk = ~clk;

  // Offers one command transaction, starting at a falling edge. Random idle cycles
  // come first; once valid is raised the payload holds until the block takes it.
  // The task returns at the falling edge after the acceptance edge.
  task automatic send_command(input logic [CMD_W-1:0] code, input logic [ELEM_W-1:0] word,
                              input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= code;
    element  <= word;
    position <= pos;
    do @(posedge clk); while (in_stall);
    sb.note_command(code, word, pos);
    @(negedge clk);
  endtask

  // Draws one command. While the list is filling, inserts dominate so that the
  // list reaches capacity and the full status shows up; while draining, removes
  // dominate until the list is empty again. About one command in ten is pure
  // noise over the whole field ranges.
  task automatic send_random_command(input bit filling);
    logic [CMD_W-1:0]  code;
    logic [POS_W-1:0]  pos;
    int unsigned       pick;
    pick = $urandom_range(99);
    pos  = POS_W'($urandom_range(511));
    if (pick < 10) begin
      code = CMD_W'($urandom_range(7));
    end else begin
      pick = $urandom_range(99);
      if (!filling) pick = (pick < 85) ? 85 + (pick % 5) : pick - 85;
      if (pick < 45)      code = CMD_INS_TAIL;
      else if (pick < 85) code = CMD_INS_HEAD;
      else if (pick < 88) code = CMD_REM_HEAD;
      else if (pick < 90) code = CMD_REM_TAIL;
      else if (pick < 93) code = CMD_RD_HEAD;
      else if (pick < 96) code = CMD_RD_TAIL;
      else                code = CMD_RD_INDEX;
      // Index reads mostly land on occupied slots, where the contents matter.
      if (sb.occupancy != 0 && $urandom_range(3) != 0) begin
        pos = POS_W'($urandom_range(sb.occupancy - 1));
      end
    end
    send_command(code, $urandom, pos);
  endtask

  initial begin : stimulus
    bit          filling;
    int unsigned dwell;
    filling = 1'b1;
    dwell   = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening: every command on the empty list, the out-of-range index
    // values, the undefined code, both extremes of the element word, reads at the
    // ends and by index, and a read past the fill count that wraps around the ring.
    send_command(CMD_RD_INDEX, 32'h0, 9'd0);
    send_command(CMD_RD_INDEX, 32'h0, 9'd256);
    send_command(CMD_RD_INDEX, 32'h0, 9'h1ff);
    send_command(CMD_REM_HEAD, 32'h0, 9'd0);
    send_command(CMD_REM_TAIL, 32'h0, 9'd0);
    send_command(CMD_RD_HEAD, 32'h0, 9'd0);
    send_command(CMD_RD_TAIL, 32'h0, 9'd0);
    send_command(CMD_UNUSED, 32'h0, 9'd0);
    send_command(CMD_INS_HEAD, 32'hffff_ffff, 9'h1ff);
    send_command(CMD_INS_TAIL, 32'h0, 9'd0);
    send_command(CMD_INS_HEAD, 32'h8000_0001, 9'd0);
    send_command(CMD_INS_TAIL, 32'h7fff_fffe, 9'd0);
    send_command(CMD_RD_HEAD, 32'h0, 9'd0);
    send_command(CMD_RD_TAIL, 32'h0, 9'd0);
    send_command(CMD_RD_INDEX, 32'h0, 9'd1);
    send_command(CMD_RD_INDEX, 32'h0, 9'd3);
    send_command(CMD_RD_INDEX, 32'h0, 9'd4);
    send_command(CMD_RD_INDEX, 32'h0, 9'd255);
    send_command(CMD_UNUSED, 32'hffff_ffff, 9'h1ff);
    send_command(CMD_REM_HEAD, 32'h0, 9'd0);
    send_command(CMD_REM_TAIL, 32'h0, 9'd0);
    send_command(CMD_RD_INDEX, 32'h0, 9'd0);
    send_command(CMD_REM_HEAD, 32'h0, 9'd0);
    send_command(CMD_REM_TAIL, 32'h0, 9'd0);
    send_command(CMD_REM_TAIL, 32'h0, 9'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // The first third idles the sender lightly and the receiver heavily, the
      // second third swaps the two rates, and the last third runs flat out.
      if (n == RANDOM_ITEMS / 3) begin
        sender_idle_pct   = 53;
        receiver_idle_pct = 26;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      // Linger a few transactions at either boundary before turning around, so
      // that full inserts and empty removes are exercised.
      if (filling ? (sb.occupancy == CAPACITY) : (sb.occupancy == 0)) begin
        dwell++;
        if (dwell > 8) begin
          filling = !filling;
          dwell   = 0;
        end
      end
      send_random_command(filling);
    end
    in_valid <= 1'b0;

    // Let every outstanding result arrive, then watch a little longer for any
    // stray result transaction.
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // The receiver decides its stall at each falling edge. Once, early in the run,
  // it refuses results for a long stretch while the sender keeps offering, so the
  // block's output fills and its input stall has to hold the sender back.
  initial begin : receiver
    bit held_off;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sb.results_seen >= 40) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // A result transaction completes at a rising edge with valid high and no stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(read_element, fill_count, status);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dedl_pkg.sv
rtl/core/dedl_ram.sv
rtl/core/dedl_ctrl.sv
rtl/core/bounded_double_ended_list_core.sv
dv/tb_top.sv
